// ===== hdl/srgp_pkg.sv =====
package srgp_pkg;

    localparam int NATIVE_WIDTH  = 960;
    localparam int NATIVE_HEIGHT = 540;
    localparam int MAX_REPLICATE = 8;

    localparam int HALF_WIDTH = NATIVE_WIDTH / 2;
    localparam int XW = $clog2(NATIVE_WIDTH);
    localparam int YW = $clog2(NATIVE_HEIGHT);
    localparam int NW = 28;          // dividend and quotient width
    localparam int PW = NW + 1;      // signed position width
    localparam int DW = 13;          // divisor width
    localparam int CW = 4;           // replicate count width, holds 1..8
    localparam int IW = 3;           // replicate index width
    localparam int AW = 18;          // byte address width

    localparam logic [2:0] REG_ROTATION  = 3'd0;
    localparam logic [2:0] REG_ORG_X     = 3'd1;
    localparam logic [2:0] REG_ORG_Y     = 3'd2;
    localparam logic [2:0] REG_DEC_W     = 3'd3;
    localparam logic [2:0] REG_DEC_H     = 3'd4;
    localparam logic [2:0] REG_TGT_W     = 3'd5;
    localparam logic [2:0] REG_TGT_H     = 3'd6;

    localparam logic [1:0] ROT_LANDSCAPE     = 2'd0;
    localparam logic [1:0] ROT_PORTRAIT      = 2'd1;
    localparam logic [1:0] ROT_INV_LANDSCAPE = 2'd2;
    localparam logic [1:0] ROT_INV_PORTRAIT  = 2'd3;

    localparam logic KIND_TABLE = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    typedef struct packed {
        logic [1:0]         rotation;
        logic signed [14:0] org_x;
        logic signed [14:0] org_y;
        logic [12:0]        decoded_width;
        logic [12:0]        decoded_height;
        logic [14:0]        target_width;
        logic [14:0]        target_height;
    } cfg_t;

    typedef struct packed {
        logic signed [PW-1:0] x0;
        logic signed [PW-1:0] y0;
        logic [CW-1:0]        cx;
        logic [CW-1:0]        cy;
        logic [3:0]           nib;
    } rect_t;

endpackage

// ===== hdl/scaled_rotated_gray4_plotter.sv =====
// operation: a pixel holds the front from accept through four divisions (each one operand
// load and 28 restoring steps) to one push, which waits while the queue is full; the back
// scans each covered destination position (up to 64 positions), one write held back for last
// the front takes no new item until the pixel has been pushed; a table load leaves it idle,
// so a new item can follow at once; the front runs ahead of the back by up to two rectangles
// reset: asynchronous active low, control state cleared, configuration set to defaults, datapath and table undefined
module scaled_rotated_gray4_plotter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [14:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [11:0] src_x,
    input  logic [11:0] src_y,
    input  logic [7:0]  luma,
    input  logic [7:0]  table_index,
    input  logic [7:0]  table_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [17:0] byte_address,
    output logic [3:0]  gray_nibble,
    output logic        upper_half,
    output logic        last
);
    import srgp_pkg::*;

    cfg_t  cfg_reg;
    logic  push, q_full, pop, q_valid;
    rect_t push_rect, q_rect;

    // configuration registers, to be written only while the block is idle; the block itself does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rotation       <= ROT_INV_PORTRAIT;
            cfg_reg.org_x          <= '0;
            cfg_reg.org_y          <= '0;
            cfg_reg.decoded_width  <= 13'd1;
            cfg_reg.decoded_height <= 13'd1;
            cfg_reg.target_width   <= 15'd1;
            cfg_reg.target_height  <= 15'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROTATION: cfg_reg.rotation       <= cfg_data[1:0];
                REG_ORG_X:    cfg_reg.org_x          <= $signed(cfg_data);
                REG_ORG_Y:    cfg_reg.org_y          <= $signed(cfg_data);
                REG_DEC_W:    cfg_reg.decoded_width  <= cfg_data[12:0];
                REG_DEC_H:    cfg_reg.decoded_height <= cfg_data[12:0];
                REG_TGT_W:    cfg_reg.target_width   <= cfg_data;
                REG_TGT_H:    cfg_reg.target_height  <= cfg_data;
                default:      ;
            endcase
        end
    end

    // front: table loads and the four scaling divisions
    srgp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .src_x       (src_x),
        .src_y       (src_y),
        .luma        (luma),
        .table_index (table_index),
        .table_value (table_value),
        .push        (push),
        .push_rect   (push_rect),
        .q_full      (q_full)
    );

    // two rectangles of slack between front and back
    srgp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_rect (push_rect),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_rect    (q_rect)
    );

    // back: scan, clip, rotate, address; holds one write back to mark the last
    srgp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .rotation     (cfg_reg.rotation),
        .q_valid      (q_valid),
        .q_rect       (q_rect),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .byte_address (byte_address),
        .gray_nibble  (gray_nibble),
        .upper_half   (upper_half),
        .last         (last)
    );

endmodule

// ===== hdl/srgp_front.sv =====
module srgp_front (
    input  logic                clk,
    input  logic                rst_n,
    input  srgp_pkg::cfg_t      cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                kind,
    input  logic [11:0]         src_x,
    input  logic [11:0]         src_y,
    input  logic [7:0]          luma,
    input  logic [7:0]          table_index,
    input  logic [7:0]          table_value,
    output logic                push,
    output srgp_pkg::rect_t     push_rect,
    input  logic                q_full
);
    import srgp_pkg::*;

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_MUL  = 4'b0010,
        F_DIV  = 4'b0100,
        F_PUSH = 4'b1000
    } fstate_t;

    fstate_t              state_reg, state_next;
    logic [7:0]           tbl [256];
    logic [7:0]           tbl_rd_reg;
    logic [11:0]          sx_reg, sy_reg;
    logic [1:0]           k_reg;
    logic [4:0]           cnt_reg;
    logic [NW-1:0]        num_reg;
    logic [DW-1:0]        rem_reg;
    logic [DW-1:0]        div_d_reg;
    logic [NW-1:0]        q_reg [4];

    logic                 accept;
    logic [12:0]          mul_a;
    logic [14:0]          mul_t;
    logic [DW-1:0]        mul_d;
    logic [NW-1:0]        numer;
    logic [DW:0]          trial;
    logic                 qbit;
    logic [DW-1:0]        rem_step;
    logic signed [PW-1:0] dx, dy;

    assign in_ready = (state_reg == F_IDLE);
    assign accept   = in_valid && in_ready;

    // contrast table
    always_ff @(posedge clk)
    begin
        if (accept && kind == KIND_TABLE)
        begin
            tbl[table_index] <= table_value;
        end
        if (accept && kind == KIND_PIXEL)
        begin
            tbl_rd_reg <= tbl[luma];
        end
    end

    // operands for the current division
    always_comb
    begin
        mul_a = k_reg[1] ? {1'b0, sy_reg} : {1'b0, sx_reg};
        mul_a = mul_a + 13'(k_reg[0]);
        mul_t = k_reg[1] ? cfg.target_height : cfg.target_width;
        mul_d = k_reg[1] ? cfg.decoded_height : cfg.decoded_width;
        if (mul_d == '0)
        begin
            mul_d = DW'(1);
        end
        numer = NW'(mul_a * mul_t) + (k_reg[0] ? NW'(mul_d - DW'(1)) : '0);
    end

    // one restoring step
    assign trial    = {rem_reg, num_reg[NW-1]};
    assign qbit     = (trial >= {1'b0, div_d_reg});
    assign rem_step = qbit ? DW'(trial - {1'b0, div_d_reg}) : trial[DW-1:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: if (accept && kind == KIND_PIXEL) state_next = F_MUL;
            F_MUL:  state_next = F_DIV;
            F_DIV:
            begin
                if (cnt_reg == 5'(NW - 1))
                begin
                    state_next = (k_reg == 2'd3) ? F_PUSH : F_MUL;
                end
            end
            F_PUSH: if (!q_full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            k_reg     <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == F_IDLE)
            begin
                k_reg <= '0;
            end
            if (state_reg == F_MUL)
            begin
                cnt_reg <= '0;
            end
            if (state_reg == F_DIV)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(NW - 1))
                begin
                    k_reg <= k_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sx_reg <= src_x;
            sy_reg <= src_y;
        end
        if (state_reg == F_MUL)
        begin
            num_reg   <= numer;
            rem_reg   <= '0;
            div_d_reg <= mul_d;
        end
        if (state_reg == F_DIV)
        begin
            rem_reg <= rem_step;
            num_reg <= {num_reg[NW-2:0], qbit};
            if (cnt_reg == 5'(NW - 1))
            begin
                q_reg[k_reg] <= {num_reg[NW-2:0], qbit};
            end
        end
    end

    // rectangle size, clamped to one..max
    always_comb
    begin
        dx = PW'($signed({1'b0, q_reg[1]}) - $signed({1'b0, q_reg[0]}));
        dy = PW'($signed({1'b0, q_reg[3]}) - $signed({1'b0, q_reg[2]}));
        push_rect.x0  = PW'(cfg.org_x) + $signed({1'b0, q_reg[0]});
        push_rect.y0  = PW'(cfg.org_y) + $signed({1'b0, q_reg[2]});
        push_rect.nib = tbl_rd_reg[7:4];
        if (dx <= 0)
            push_rect.cx = CW'(1);
        else if (dx > PW'(MAX_REPLICATE))
            push_rect.cx = CW'(MAX_REPLICATE);
        else
            push_rect.cx = dx[CW-1:0];
        if (dy <= 0)
            push_rect.cy = CW'(1);
        else if (dy > PW'(MAX_REPLICATE))
            push_rect.cy = CW'(MAX_REPLICATE);
        else
            push_rect.cy = dy[CW-1:0];
    end

    assign push = (state_reg == F_PUSH) && !q_full;

endmodule

// ===== hdl/srgp_queue.sv =====
module srgp_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  srgp_pkg::rect_t  push_rect,
    output logic             full,
    input  logic             pop,
    output logic             q_valid,
    output srgp_pkg::rect_t  q_rect
);
    import srgp_pkg::*;

    rect_t      mem [2];
    logic       wp_reg, rp_reg;
    logic [1:0] count_reg;

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_rect  = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wp_reg] <= push_rect;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= 1'b0;
            rp_reg    <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// ===== hdl/srgp_back.sv =====
module srgp_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       rotation,
    input  logic             q_valid,
    input  srgp_pkg::rect_t  q_rect,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [17:0]      byte_address,
    output logic [3:0]       gray_nibble,
    output logic             upper_half,
    output logic             last
);
    import srgp_pkg::*;

    typedef enum logic [3:0] {
        B_IDLE  = 4'b0001,
        B_CALC  = 4'b0010,
        B_PUT   = 4'b0100,
        B_FLUSH = 4'b1000
    } bstate_t;

    bstate_t              state_reg, state_next;
    rect_t                rect_reg;
    logic [IW-1:0]        i_reg, j_reg;
    logic                 vis_reg, end_reg;
    logic [XW-1:0]        nx_reg;
    logic [YW-1:0]        ny_reg;
    logic                 pend_valid_reg;
    logic [AW-1:0]        pend_addr_reg;
    logic                 pend_half_reg;
    logic                 out_valid_reg;

    logic signed [PW-1:0] lx, ly, lw, lh, px, py;
    logic                 vis;
    logic                 can_move;
    logic                 stall;
    logic                 out_load;
    logic                 out_last;
    logic [AW-1:0]        cand_addr;

    // clip to the logical screen, then rotate
    always_comb
    begin
        lx  = rect_reg.x0 + PW'(i_reg);
        ly  = rect_reg.y0 + PW'(j_reg);
        lw  = rotation[0] ? PW'(NATIVE_HEIGHT) : PW'(NATIVE_WIDTH);
        lh  = rotation[0] ? PW'(NATIVE_WIDTH) : PW'(NATIVE_HEIGHT);
        vis = (lx >= 0) && (ly >= 0) && (lx < lw) && (ly < lh);
        unique case (rotation)
            ROT_LANDSCAPE:
            begin
                px = lx;
                py = ly;
            end
            ROT_PORTRAIT:
            begin
                px = PW'(NATIVE_WIDTH - 1) - ly;
                py = lx;
            end
            ROT_INV_LANDSCAPE:
            begin
                px = PW'(NATIVE_WIDTH - 1) - lx;
                py = PW'(NATIVE_HEIGHT - 1) - ly;
            end
            ROT_INV_PORTRAIT:
            begin
                px = ly;
                py = PW'(NATIVE_HEIGHT - 1) - lx;
            end
            default:
            begin
                px = lx;
                py = ly;
            end
        endcase
    end

    assign cand_addr = AW'(32'(ny_reg) * HALF_WIDTH + 32'(nx_reg >> 1));
    assign can_move  = !out_valid_reg || out_ready;
    assign stall     = (state_reg == B_PUT) && vis_reg && pend_valid_reg && !can_move;
    assign pop       = (state_reg == B_IDLE) && q_valid;

    always_comb
    begin
        out_load = 1'b0;
        out_last = 1'b0;
        if (state_reg == B_PUT && vis_reg && pend_valid_reg && can_move)
        begin
            out_load = 1'b1;
        end
        if (state_reg == B_FLUSH && pend_valid_reg && can_move)
        begin
            out_load = 1'b1;
            out_last = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: if (q_valid) state_next = B_CALC;
            B_CALC: state_next = B_PUT;
            B_PUT:
            begin
                if (!stall)
                begin
                    state_next = end_reg ? B_FLUSH : B_CALC;
                end
            end
            B_FLUSH:
            begin
                if (!pend_valid_reg || can_move)
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            i_reg          <= '0;
            j_reg          <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
            begin
                i_reg <= '0;
                j_reg <= '0;
            end
            if (state_reg == B_PUT && !stall)
            begin
                if (vis_reg)
                begin
                    pend_valid_reg <= 1'b1;
                end
                if (CW'(i_reg) == rect_reg.cx - CW'(1))
                begin
                    i_reg <= '0;
                    j_reg <= j_reg + IW'(1);
                end
                else
                begin
                    i_reg <= i_reg + IW'(1);
                end
            end
            if (state_reg == B_FLUSH && can_move)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rect_reg <= q_rect;
        end
        if (state_reg == B_CALC)
        begin
            vis_reg <= vis;
            nx_reg  <= px[XW-1:0];
            ny_reg  <= py[YW-1:0];
            end_reg <= (CW'(i_reg) == rect_reg.cx - CW'(1))
                    && (CW'(j_reg) == rect_reg.cy - CW'(1));
        end
        if (state_reg == B_PUT && !stall && vis_reg)
        begin
            pend_addr_reg <= cand_addr;
            pend_half_reg <= nx_reg[0];
        end
        if (out_load)
        begin
            byte_address <= pend_addr_reg;
            upper_half   <= pend_half_reg;
            gray_nibble  <= rect_reg.nib;
            last         <= out_last;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import srgp_pkg::*;

    // one source item as offered to the block
    typedef struct {
        logic        kind;
        logic [11:0] src_x;
        logic [11:0] src_y;
        logic [7:0]  luma;
        logic [7:0]  table_index;
        logic [7:0]  table_value;
    } src_item_t;

    // one framebuffer write as the block should produce it
    typedef struct {
        logic [17:0] byte_address;
        logic [3:0]  gray_nibble;
        logic        upper_half;
        logic        last;
    } fb_write_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [14:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        kind;
    logic [11:0] src_x;
    logic [11:0] src_y;
    logic [7:0]  luma;
    logic [7:0]  table_index;
    logic [7:0]  table_value;
    logic        out_valid;
    logic        out_ready;
    logic [17:0] byte_address;
    logic [3:0]  gray_nibble;
    logic        upper_half;
    logic        last;

    // items waiting to be offered, and writes still owed by the block
    src_item_t   pending_items[$];
    fb_write_t   owed_writes[$];

    // shadow of the block's settings and contrast table
    logic [1:0]  sh_rotation;
    int          sh_org_x;
    int          sh_org_y;
    int          sh_dec_w;
    int          sh_dec_h;
    int          sh_tgt_w;
    int          sh_tgt_h;
    logic [7:0]  sh_table[256];
    bit          sh_loaded[256];
    byte unsigned loaded_list[$];

    int          error_count;
    bit          in_taken;
    bit          calm;       // no idling on either side
    bit          hold_go;    // request for a long receiver hold-off
    bit          hold_seen;
    int          hold_cnt;

    scaled_rotated_gray4_plotter u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .src_x        (src_x),
        .src_y        (src_y),
        .luma         (luma),
        .table_index  (table_index),
        .table_value  (table_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .byte_address (byte_address),
        .gray_nibble  (gray_nibble),
        .upper_half   (upper_half),
        .last         (last)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // clip and rotate one logical position, pushing a write when visible
    task automatic plot_position(input longint lx, input longint ly, input logic [3:0] nib);
        longint    lw;
        longint    lh;
        longint    px;
        longint    py;
        fb_write_t w;
        lw = sh_rotation[0] ? NATIVE_HEIGHT : NATIVE_WIDTH;
        lh = sh_rotation[0] ? NATIVE_WIDTH : NATIVE_HEIGHT;
        if (lx < 0 || ly < 0 || lx >= lw || ly >= lh)
            return;
        case (sh_rotation)
            ROT_LANDSCAPE:
            begin
                px = lx;
                py = ly;
            end
            ROT_PORTRAIT:
            begin
                px = (NATIVE_WIDTH - 1) - ly;
                py = lx;
            end
            ROT_INV_LANDSCAPE:
            begin
                px = (NATIVE_WIDTH - 1) - lx;
                py = (NATIVE_HEIGHT - 1) - ly;
            end
            default:
            begin
                px = ly;
                py = (NATIVE_HEIGHT - 1) - lx;
            end
        endcase
        if (px < 0 || py < 0 || px >= NATIVE_WIDTH || py >= NATIVE_HEIGHT)
            return;
        w.byte_address = 18'(py * HALF_WIDTH + px / 2);
        w.gray_nibble  = nib;
        w.upper_half   = px[0];
        w.last         = 1'b0;
        owed_writes.push_back(w);
    endtask

    // expand one accepted item into the writes it should cause
    task automatic predict_writes(input src_item_t it);
        longint     dw;
        longint     dh;
        longint     x0;
        longint     x1;
        longint     y0;
        longint     y1;
        longint     cx;
        longint     cy;
        int         before_n;
        logic [3:0] nib;
        if (it.kind == KIND_TABLE)
        begin
            sh_table[it.table_index] = it.table_value;
            return;
        end
        nib = sh_table[it.luma][7:4];
        dw  = (sh_dec_w != 0) ? sh_dec_w : 1;
        dh  = (sh_dec_h != 0) ? sh_dec_h : 1;
        x0  = sh_org_x + (longint'(it.src_x) * sh_tgt_w) / dw;
        x1  = sh_org_x + ((longint'(it.src_x) + 1) * sh_tgt_w + dw - 1) / dw;
        y0  = sh_org_y + (longint'(it.src_y) * sh_tgt_h) / dh;
        y1  = sh_org_y + ((longint'(it.src_y) + 1) * sh_tgt_h + dh - 1) / dh;
        if (x1 <= x0)
            x1 = x0 + 1;
        if (y1 <= y0)
            y1 = y0 + 1;
        cx = (x1 - x0 > MAX_REPLICATE) ? MAX_REPLICATE : x1 - x0;
        cy = (y1 - y0 > MAX_REPLICATE) ? MAX_REPLICATE : y1 - y0;
        before_n = owed_writes.size();
        for (longint j = 0; j < cy; j++)
            for (longint i = 0; i < cx; i++)
                plot_position(x0 + i, y0 + j, nib);
        if (owed_writes.size() > before_n)
            owed_writes[owed_writes.size() - 1].last = 1'b1;
    endtask

    // input side: note acceptances and predict at the rising edge
    always @(posedge clk)
    begin
        src_item_t it;
        in_taken = in_valid && in_ready;
        if (in_taken)
        begin
            it.kind        = kind;
            it.src_x       = src_x;
            it.src_y       = src_y;
            it.luma        = luma;
            it.table_index = table_index;
            it.table_value = table_value;
            predict_writes(it);
        end
    end

    // output side: compare each accepted write with the oldest owed one
    always @(posedge clk)
    begin
        fb_write_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (owed_writes.size() == 0)
            begin
                report_mismatch("write not owed, address", byte_address, -1);
            end
            else
            begin
                w = owed_writes.pop_front();
                if (byte_address !== w.byte_address)
                    report_mismatch("byte_address", byte_address, w.byte_address);
                if (gray_nibble !== w.gray_nibble)
                    report_mismatch("gray_nibble", gray_nibble, w.gray_nibble);
                if (upper_half !== w.upper_half)
                    report_mismatch("upper_half", upper_half, w.upper_half);
                if (last !== w.last)
                    report_mismatch("last", last, w.last);
            end
        end
    end

    // driver: a new item only once the previous one was taken
    always @(negedge clk)
    begin
        src_item_t it;
        if (rst_n && (!in_valid || in_taken))
        begin
            if (pending_items.size() > 0 && (calm || $urandom_range(0, 99) >= 27))
            begin
                it = pending_items.pop_front();
                in_valid    <= 1'b1;
                kind        <= it.kind;
                src_x       <= it.src_x;
                src_y       <= it.src_y;
                luma        <= it.luma;
                table_index <= it.table_index;
                table_value <= it.table_value;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_go && !hold_seen)
            hold_cnt = 3000;
        hold_seen = hold_go;
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= calm || ($urandom_range(0, 99) >= 27);
    end

    task automatic write_reg(input logic [2:0] idx, input logic [14:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_ROTATION: sh_rotation = val[1:0];
            REG_ORG_X:    sh_org_x    = int'($signed(val));
            REG_ORG_Y:    sh_org_y    = int'($signed(val));
            REG_DEC_W:    sh_dec_w    = int'(val[12:0]);
            REG_DEC_H:    sh_dec_h    = int'(val[12:0]);
            REG_TGT_W:    sh_tgt_w    = int'(val);
            default:      sh_tgt_h    = int'(val);
        endcase
    endtask

    task automatic apply_settings(input int rot, input int ox, input int oy,
                                  input int dw, input int dh, input int tw, input int th);
        write_reg(REG_ROTATION, 15'(rot));
        write_reg(REG_ORG_X, 15'(ox));
        write_reg(REG_ORG_Y, 15'(oy));
        write_reg(REG_DEC_W, 15'(dw));
        write_reg(REG_DEC_H, 15'(dh));
        write_reg(REG_TGT_W, 15'(tw));
        write_reg(REG_TGT_H, 15'(th));
    endtask

    // wait until all items are in, nothing is owed and the block has gone quiet
    task automatic drain;
        int quiet;
        while (pending_items.size() != 0 || in_valid)
            @(posedge clk);
        quiet = 0;
        while (quiet < 700)
        begin
            @(posedge clk);
            if (owed_writes.size() == 0 && !out_valid)
                quiet++;
            else
                quiet = 0;
        end
    endtask

    function automatic src_item_t table_item(input int idx, input int val);
        src_item_t it;
        it.kind        = KIND_TABLE;
        it.src_x       = 12'($urandom);
        it.src_y       = 12'($urandom);
        it.luma        = 8'($urandom);
        it.table_index = 8'(idx);
        it.table_value = 8'(val);
        if (!sh_loaded[idx])
            loaded_list.push_back(8'(idx));
        sh_loaded[idx] = 1'b1;
        return it;
    endfunction

    // luma only ever selects a table entry that has been loaded
    function automatic src_item_t pixel_item(input int sx, input int sy);
        src_item_t it;
        it.kind        = KIND_PIXEL;
        it.src_x       = 12'(sx);
        it.src_y       = 12'(sy);
        it.luma        = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
        it.table_index = 8'($urandom);
        it.table_value = 8'($urandom);
        return it;
    endfunction

    function automatic src_item_t random_item(input int dw, input int dh);
        if ($urandom_range(0, 9) == 0)
            return table_item($urandom_range(0, 255), $urandom_range(0, 255));
        if ($urandom_range(0, 9) == 0)
            return pixel_item($urandom_range(0, 4095), $urandom_range(0, 4095));
        return pixel_item($urandom_range(0, (dw > 4095) ? 4095 : dw),
                          $urandom_range(0, (dh > 4095) ? 4095 : dh));
    endfunction

    initial
    begin
        int dw;
        int dh;
        int tw;
        int th;
        error_count = 0;
        calm        = 1'b0;
        hold_go     = 1'b0;
        hold_seen   = 1'b0;
        hold_cnt    = 0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = REG_ROTATION;
        cfg_data    = '0;
        in_valid    = 1'b0;
        kind        = KIND_TABLE;
        src_x       = '0;
        src_y       = '0;
        luma        = '0;
        table_index = '0;
        table_value = '0;
        out_ready   = 1'b0;
        in_taken    = 1'b0;
        // reset values of the settings
        sh_rotation = ROT_INV_PORTRAIT;
        sh_org_x    = 0;
        sh_org_y    = 0;
        sh_dec_w    = 1;
        sh_dec_h    = 1;
        sh_tgt_w    = 1;
        sh_tgt_h    = 1;
        for (int i = 0; i < 256; i++)
        begin
            sh_table[i]  = 8'h00;
            sh_loaded[i] = 1'b0;
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: table extremes, then pixels under the reset settings
        pending_items.push_back(table_item(0, 8'hFF));
        pending_items.push_back(table_item(255, 8'h00));
        pending_items.push_back(table_item(128, 8'h0F));
        pending_items.push_back(table_item(127, 8'hF0));
        pending_items.push_back(pixel_item(0, 0));
        pending_items.push_back(pixel_item(4095, 4095));
        pending_items.push_back(pixel_item(0, 4095));
        pending_items.push_back(pixel_item(4095, 0));
        drain();

        // directed: upscale capped at 8x8, every rotation
        for (int r = 0; r < 4; r++)
        begin
            apply_settings(r, 100, 100, 1, 1, 16384, 16384);
            pending_items.push_back(pixel_item(0, 0));
            drain();
        end
        // zero decoded and zero target sizes
        apply_settings(ROT_LANDSCAPE, 0, 0, 0, 0, 0, 0);
        pending_items.push_back(pixel_item(5, 7));
        pending_items.push_back(pixel_item(0, 0));
        drain();
        // offset extremes: everything clipped
        apply_settings(ROT_PORTRAIT, -16384, 16383, 4096, 4096, 16384, 16384);
        pending_items.push_back(pixel_item(0, 0));
        pending_items.push_back(pixel_item(4095, 4095));
        drain();
        apply_settings(ROT_INV_LANDSCAPE, 16383, -16384, 4096, 4096, 16384, 16384);
        pending_items.push_back(pixel_item(4095, 4095));
        drain();
        // right at the screen edge, part clipped
        apply_settings(ROT_LANDSCAPE, 955, 535, 1, 1, 8, 8);
        pending_items.push_back(pixel_item(0, 0));
        drain();

        // random phases with varied settings
        for (int p = 0; p < 10; p++)
        begin
            dw = $urandom_range(1, 40);
            dh = $urandom_range(1, 40);
            tw = dw * $urandom_range(1, 3) + $urandom_range(0, dw);
            th = dh * $urandom_range(1, 3) + $urandom_range(0, dh);
            if (p == 8)
            begin
                dw = 4096;
                dh = 4096;
                tw = $urandom_range(1, 16384);
                th = $urandom_range(1, 16384);
            end
            apply_settings(p % 4, $urandom_range(0, 1) ? int'($urandom_range(0, 500))
                                                       : -int'($urandom_range(0, 20)),
                           $urandom_range(0, 1) ? int'($urandom_range(0, 500))
                                                : -int'($urandom_range(0, 20)),
                           dw, dh, tw, th);
            calm = (p == 3);
            for (int k = 0; k < 40; k++)
                pending_items.push_back(random_item(dw, dh));
            if (p == 5)
            begin
                // long receiver hold-off while items keep coming
                @(posedge clk);
                hold_go = 1'b1;
            end
            drain();
            hold_go = 1'b0;
        end

        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
